>>> rtl/glpf_pkg.sv
// Shared types and constants for the grid local peak finder.
// Used by glpf_ctrl, glpf_dp and grid_local_peak_finder_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package glpf_pkg;

  localparam int ROWS_W      = 8;
  localparam int COLS_W      = 6;
  localparam int PEAK_ROW_W  = 7;
  localparam int PEAK_COL_W  = 5;
  localparam int OUT_DATA_W  = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 8'd128;
  localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_JUDGE,
    S_FL_READ,
    S_FL_JUDGE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_norm;
    logic judge_norm;
    logic fl_rd;
    logic fl_judge;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic fl_last;
    logic cand_valid;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/glpf_ctrl.sv
// Sequencing state machine of the grid local peak finder.
// Issues commands to glpf_dp and reads its status; uses glpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glpf_ctrl
  import glpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        if (status.out_free) state_next = status.frame_end ? S_FL_READ : S_FINISH;
      end
      S_FL_READ: begin
        state_next = S_FL_JUDGE;
      end
      S_FL_JUDGE: begin
        if (status.out_free) state_next = status.fl_last ? S_FINISH : S_FL_READ;
      end
      S_FINISH: begin
        if (!status.cand_valid || status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_READ: begin
        cmd.rd_norm = 1'b1;
      end
      S_JUDGE: begin
        cmd.judge_norm = status.out_free;
      end
      S_FL_READ: begin
        cmd.fl_rd = 1'b1;
      end
      S_FL_JUDGE: begin
        cmd.fl_judge = status.out_free;
      end
      S_FINISH: begin
        cmd.finish = !status.cand_valid || status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_READ)
    else $error("accepted item did not start its memory read");

endmodule

`default_nettype wire

>>> rtl/glpf_dp.sv
// Datapath of the grid local peak finder: row stores, position counters,
// neighbor compare, pending-peak register and output register. Uses glpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glpf_dp
  import glpf_pkg::*;
#(
  parameter int MAX_ROWS    = 128,
  parameter int MAX_COLS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [SAMPLE_BITS-1:0] pixel,
  input  logic [ROWS_W-1:0]             num_rows,
  input  logic [COLS_W-1:0]             num_cols,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_DATA_W-1:0]         m_tdata,
  output logic                          m_tlast
);

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PAD_W  = OUT_DATA_W - PEAK_ROW_W - PEAK_COL_W;
  localparam logic [ROWS_W-1:0] ROWS_CAP = (MAX_ROWS > 255) ? 8'd255 : ROWS_W'(MAX_ROWS);
  localparam logic [COLS_W-1:0] COLS_CAP = COLS_W'(MAX_COLS);

  logic signed [SAMPLE_BITS-1:0] older_mem [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] newer_mem [MAX_COLS];

  logic signed [SAMPLE_BITS-1:0] pix;
  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] old_a;
  logic signed [SAMPLE_BITS-1:0] old_b;
  logic signed [SAMPLE_BITS-1:0] new_a;
  logic signed [SAMPLE_BITS-1:0] new_b;
  logic [ROWS_W-1:0] r;
  logic [COLS_W-1:0] c;
  logic [COLS_W-1:0] cols;
  logic [COLS_W-1:0] k;
  logic              last_col;
  logic              last_row;
  logic [ROWS_W-1:0] row_cnt;
  logic [COLS_W-1:0] col_cnt;
  logic                  cand_valid;
  logic [PEAK_ROW_W-1:0] cand_row;
  logic [PEAK_COL_W-1:0] cand_col;
  logic [PEAK_ROW_W-1:0] out_row;
  logic [PEAK_COL_W-1:0] out_col;
  logic                  out_last;

  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] r_eff;
  logic [COLS_W-1:0] c_eff;
  logic              lc_eff;
  logic              lr_eff;
  logic [COLS_W-1:0] c_m1;
  logic [COLS_W-1:0] c_p1;
  logic [COLS_W-1:0] k_p1;
  logic              fl_last;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_ob;
  logic [ADDR_W-1:0] addr_nb;
  logic signed [SAMPLE_BITS-1:0] left_v;
  logic signed [SAMPLE_BITS-1:0] right_v;
  logic signed [SAMPLE_BITS-1:0] down_v;
  logic              hit;
  logic              peak_found;
  logic [ROWS_W-1:0] found_row;
  logic [COLS_W-1:0] found_col;
  logic              out_free;
  logic              out_load;

  always_comb begin
    rows_eff = (num_rows == '0) ? ROWS_W'(1) : ((num_rows > ROWS_CAP) ? ROWS_CAP : num_rows);
    cols_eff = (num_cols == '0) ? COLS_W'(1) : ((num_cols > COLS_CAP) ? COLS_CAP : num_cols);
    r_eff    = (row_cnt >= rows_eff) ? rows_eff - ROWS_W'(1) : row_cnt;
    c_eff    = (col_cnt >= cols_eff) ? cols_eff - COLS_W'(1) : col_cnt;
    lc_eff   = ({1'b0, c_eff} + (COLS_W + 1)'(1)) >= {1'b0, cols_eff};
    lr_eff   = ({1'b0, r_eff} + (ROWS_W + 1)'(1)) >= {1'b0, rows_eff};
  end

  always_comb begin
    c_m1    = c - COLS_W'(1);
    c_p1    = last_col ? '0 : c + COLS_W'(1);
    fl_last = ({1'b0, k} + (COLS_W + 1)'(1)) >= {1'b0, cols};
    k_p1    = fl_last ? '0 : k + COLS_W'(1);
    addr_a  = cmd.rd_norm ? c[ADDR_W-1:0] : k[ADDR_W-1:0];
    addr_ob = c_m1[ADDR_W-1:0];
    addr_nb = cmd.rd_norm ? c_p1[ADDR_W-1:0] : k_p1[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_norm || cmd.fl_rd) begin
      old_a <= older_mem[addr_a];
      old_b <= older_mem[addr_ob];
      new_a <= newer_mem[addr_a];
      new_b <= newer_mem[addr_nb];
    end
    if (cmd.judge_norm) begin
      older_mem[c[ADDR_W-1:0]] <= (r != '0) ? new_a : '0;
      newer_mem[c[ADDR_W-1:0]] <= pix;
    end
  end

  always_comb begin
    down_v     = cmd.judge_norm ? pix : '0;
    left_v     = cmd.judge_norm ? ((c != '0) ? old_b : '0) : left;
    right_v    = (cmd.fl_judge ? fl_last : last_col) ? '0 : new_b;
    hit        = (new_a >= old_a) && (new_a >= left_v) && (new_a >= down_v)
                 && (new_a >= right_v);
    peak_found = hit && ((cmd.judge_norm && (r != '0)) || cmd.fl_judge);
    found_row  = cmd.judge_norm ? r - ROWS_W'(1) : r;
    found_col  = cmd.judge_norm ? c : k;
    out_free   = !m_tvalid || m_tready;
    out_load   = cand_valid && (peak_found || cmd.finish);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix      <= pixel;
      r        <= r_eff;
      c        <= c_eff;
      cols     <= cols_eff;
      last_col <= lc_eff;
      last_row <= lr_eff;
    end
    if (cmd.judge_norm) begin
      k    <= '0;
      left <= '0;
    end else if (cmd.fl_judge) begin
      k    <= k + COLS_W'(1);
      left <= new_a;
    end
    if (peak_found) begin
      cand_row <= found_row[PEAK_ROW_W-1:0];
      cand_col <= found_col[PEAK_COL_W-1:0];
    end
    if (out_load) begin
      out_row  <= cand_row;
      out_col  <= cand_col;
      out_last <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt    <= '0;
      col_cnt    <= '0;
      cand_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (lc_eff) begin
          col_cnt <= '0;
          row_cnt <= lr_eff ? '0 : r_eff + ROWS_W'(1);
        end else begin
          col_cnt <= c_eff + COLS_W'(1);
          row_cnt <= r_eff;
        end
      end
      if (peak_found) begin
        cand_valid <= 1'b1;
      end else if (cmd.finish) begin
        cand_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_col, out_row};
  assign m_tlast = out_last;

  always_comb begin
    status.out_free   = out_free;
    status.frame_end  = last_col && last_row;
    status.fl_last    = fl_last;
    status.cand_valid = cand_valid;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten before it was taken");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= COLS_CAP)
    else $error("column counter beyond the largest grid width");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_load && cmd.finish |=> !cand_valid)
    else $error("pending peak left behind after the final result");

endmodule

`default_nettype wire

>>> rtl/grid_local_peak_finder_unit.sv
// Grid local peak finder: streams grid samples in row-major order and reports
// every four-neighbor local maximum with zero padding at the borders.
// Usage:
//   s_tvalid/s_tready/s_tdata carry one sample per item in s_tdata[SAMPLE_BITS-1:0].
//   m_tvalid/m_tready/m_tdata/m_tlast carry one peak per item: m_tdata[6:0] is
//   the row, m_tdata[11:7] the column; m_tlast marks the last peak caused by
//   one input item. An input item that completes no peak produces no output.
//   The APB port sets num_rows (address 0) and num_cols (address 4); write it
//   only while the block is idle. A cell is judged when the sample below it
//   arrives; the last sample of a frame also judges the whole last row.
// Each item goes through the shared row-store read and compare step; the last
// item of a frame also runs that step once per column for the row flush.
// Each peak waits in a pending register until the next peak or the end of its
// item fixes m_tlast, then moves to the output register. While the receiver
// holds m_tready low, the sequencer waits at the next result and s_tready stays
// low until that item is finished.
// Reset clears the position counters and sets the size to 128 rows by 32
// columns; the row stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module grid_local_peak_finder_unit
  import glpf_pkg::*;
#(
  parameter int MAX_ROWS    = 128,
  parameter int MAX_COLS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: pixel_value
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // m_tdata: peak_row, peak_col
  output logic [OUT_DATA_W-1:0]               m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic                                m_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [APB_ADDR_W-1:0]               paddr,
  input  logic [APB_DATA_W-1:0]               pwdata,
  output logic [APB_DATA_W-1:0]               prdata,
  output logic                                pready
);

  logic [ROWS_W-1:0] num_rows;
  logic [COLS_W-1:0] num_cols;
  logic              cfg_write;
  cmd_t              cmd;
  status_t           status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= ROWS_RESET;
      num_cols <= COLS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_NUM_ROWS: num_rows <= pwdata[ROWS_W-1:0];
        REG_NUM_COLS: num_cols <= pwdata[COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_ROWS: prdata = {{(APB_DATA_W - ROWS_W){1'b0}}, num_rows};
      REG_NUM_COLS: prdata = {{(APB_DATA_W - COLS_W){1'b0}}, num_cols};
      default:      prdata = '0;
    endcase
  end

  glpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  glpf_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .pixel    (s_tdata[SAMPLE_BITS-1:0]),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for grid_local_peak_finder_unit: streams grids of samples,
// predicts every four-neighbor peak and compares each output item against it.
// Depends on rtl/glpf_pkg.sv and rtl/grid_local_peak_finder_unit.sv.
`timescale 1ns / 1ps

module tb;
  import glpf_pkg::*;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 55;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    logic [PEAK_ROW_W-1:0] row;
    logic [PEAK_COL_W-1:0] col;
    logic                  last;
  } peak_t;

  class peak_tracker;
    sample_t older_row[MAX_COLS];
    sample_t newer_row[MAX_COLS];
    int row_cnt;
    int col_cnt;
    logic [ROWS_W-1:0] num_rows;
    logic [COLS_W-1:0] num_cols;
    peak_t pending_peaks[$];
    int mismatches;

    function new();
      foreach (older_row[k]) begin
        older_row[k] = '0;
        newer_row[k] = '0;
      end
      row_cnt = 0;
      col_cnt = 0;
      num_rows = ROWS_RESET;
      num_cols = COLS_RESET;
      mismatches = 0;
    endfunction

    function int clamp_dim(int v, int max_v);
      if (v == 0) return 1;
      return (v > max_v) ? max_v : v;
    endfunction

    function int eff_rows();
      return clamp_dim(num_rows, MAX_ROWS);
    endfunction

    function int eff_cols();
      return clamp_dim(num_cols, MAX_COLS);
    endfunction

    function void set_reg(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_NUM_ROWS) begin
        num_rows = value[ROWS_W-1:0];
      end else begin
        num_cols = value[COLS_W-1:0];
      end
    endfunction

    function int to_frame_end();
      int rows;
      int cols;
      int r;
      int c;
      rows = eff_rows();
      cols = eff_cols();
      r = (row_cnt >= rows) ? rows - 1 : row_cnt;
      c = (col_cnt >= cols) ? cols - 1 : col_cnt;
      return (rows - 1 - r) * cols + (cols - c);
    endfunction

    function bit is_peak(sample_t ctr, sample_t up, sample_t left, sample_t down,
                         sample_t right);
      return ctr >= up && ctr >= left && ctr >= down && ctr >= right;
    endfunction

    function void add_peak(int r, int c);
      peak_t p;
      p.row = r[PEAK_ROW_W-1:0];
      p.col = c[PEAK_COL_W-1:0];
      p.last = 1'b0;
      pending_peaks.push_back(p);
    endfunction

    function void take_pixel(sample_t v);
      int rows;
      int cols;
      int r;
      int c;
      int first_new;
      sample_t left;
      sample_t right;
      sample_t zero;
      zero = '0;
      rows = eff_rows();
      cols = eff_cols();
      r = (row_cnt >= rows) ? rows - 1 : row_cnt;
      c = (col_cnt >= cols) ? cols - 1 : col_cnt;
      first_new = pending_peaks.size();
      if (r > 0) begin
        left = (c > 0) ? older_row[c-1] : zero;
        right = (c + 1 < cols) ? newer_row[c+1] : zero;
        if (is_peak(newer_row[c], older_row[c], left, v, right)) add_peak(r - 1, c);
        older_row[c] = newer_row[c];
      end else begin
        older_row[c] = zero;
      end
      newer_row[c] = v;
      if (c + 1 >= cols) begin
        col_cnt = 0;
        if (r + 1 >= rows) begin
          for (int k = 0; k < cols; k++) begin
            left = (k > 0) ? newer_row[k-1] : zero;
            right = (k + 1 < cols) ? newer_row[k+1] : zero;
            if (is_peak(newer_row[k], older_row[k], left, zero, right)) add_peak(r, k);
          end
          row_cnt = 0;
        end else begin
          row_cnt = r + 1;
        end
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
      if (pending_peaks.size() > first_new) pending_peaks[$].last = 1'b1;
    endfunction

    function void check_peak(logic [OUT_DATA_W-1:0] data, logic tlast);
      peak_t want;
      logic [PEAK_ROW_W-1:0] got_row;
      logic [PEAK_COL_W-1:0] got_col;
      logic [OUT_DATA_W-PEAK_ROW_W-PEAK_COL_W-1:0] got_pad;
      got_row = data[PEAK_ROW_W-1:0];
      got_col = data[PEAK_ROW_W+PEAK_COL_W-1:PEAK_ROW_W];
      got_pad = data[OUT_DATA_W-1:PEAK_ROW_W+PEAK_COL_W];
      if (pending_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected peak item: row %0d col %0d last %b", got_row, got_col, tlast);
        return;
      end
      want = pending_peaks.pop_front();
      if (got_row !== want.row || got_col !== want.col || got_pad !== '0 ||
          tlast !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Peak mismatch: expected row %0d col %0d last %b, got row %0d col %0d last %b pad %h",
                   want.row, want.col, want.last, got_row, got_col, tlast, got_pad);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [SAMPLE_BITS-1:0] s_tdata;
  logic s_tvalid;
  logic s_tready;
  logic m_tvalid;
  logic m_tready;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  peak_tracker sb;
  int src_idle_pct;
  int snk_idle_pct;
  int random_items;
  int cycle_cnt;

  grid_local_peak_finder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_peak(m_tdata, m_tlast);
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(4)) - sample_t'(2);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input sample_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = v;
    do @(posedge clk); while (!s_tready);
    sb.take_pixel(v);
    @(negedge clk);
  endtask

  task automatic send_run(input int n);
    repeat (n) begin
      send_pixel(rand_sample());
      random_items++;
    end
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = APB_ADDR_W'({idx, 2'b00});
    pwdata = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, APB_DATA_W'(value));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input int rows, input int cols);
    wait_idle();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
  endtask

  task automatic run_segment();
    int rows;
    int cols;
    int n;
    rows = $urandom_range(6);
    cols = $urandom_range(8);
    if (sb.row_cnt != 0 && sb.clamp_dim(cols, MAX_COLS) > sb.eff_cols()) cols = sb.eff_cols();
    configure(rows, cols);
    n = sb.to_frame_end();
    if ($urandom_range(3) == 0) n = $urandom_range(1, n);
    send_run(n);
  endtask

  initial begin : stimulus
    sample_t grid_a[12] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000,
                            -16'sd1, 16'sh7FFF, -16'sd1, 16'sh8000,
                            16'sh8000, 16'sd2, 16'sd2, 16'sh8000};
    sample_t cells[4] = '{16'sh7FFF, -16'sd1, 16'sh0000, 16'sh8000};
    sample_t grid_b[4] = '{16'sd5, -16'sd5, 16'sd7, 16'sd7};
    int ext_rows[3] = '{2, 1, 255};
    int ext_cols[3] = '{63, 32, 1};
    int phase_start;

    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(3, 4);
    foreach (grid_a[k]) send_pixel(grid_a[k]);
    configure(0, 0);
    foreach (cells[k]) send_pixel(cells[k]);
    configure(4, 3);
    foreach (grid_b[k]) send_pixel(grid_b[k]);
    configure(2, 2);
    send_pixel(16'sh8000);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 77 : 0;
      snk_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 11 : 0;
      phase_start = random_items;
      if (sb.row_cnt != 0 || sb.col_cnt != 0) send_run(sb.to_frame_end());
      configure(ext_rows[ph], ext_cols[ph]);
      send_run(sb.to_frame_end());
      while (random_items - phase_start < PHASE_ITEMS) run_segment();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending_peaks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> grid_local_peak_finder_unit.f
rtl/glpf_pkg.sv
rtl/glpf_ctrl.sv
rtl/glpf_dp.sv
rtl/grid_local_peak_finder_unit.sv
test/tb.sv
